// ===== hw/rtl/rotate_three_points_about_center_defines.svh =====
// ----------------------------------------------------------------------------
// Clock hand rotator: assertion macros
// Immediate-implication and next-cycle checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef ROTATE_THREE_POINTS_ABOUT_CENTER_DEFINES_SVH
`define ROTATE_THREE_POINTS_ABOUT_CENTER_DEFINES_SVH

// cons must hold in the same cycle as ante
`define RTPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// cons must hold in the cycle after ante
`define RTPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/rtpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Clock hand rotator: package
// Widths, reset values, register codes, CORDIC arctangent table, control types.
// ----------------------------------------------------------------------------
package rtpc_pkg;

	localparam int COORD_W    = 32;
	localparam int MS_W       = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int XY_W       = 40;   // offset * 16 plus CORDIC growth
	localparam int ACC_W      = 64;
	localparam int IDX_W      = 5;    // arctangent table index
	localparam int OUT_SHIFT  = 28;

	localparam logic [23:0] GAIN_Q24   = 24'd10188014;
	localparam logic [31:0] HALF_QUAD  = 32'h2000_0000;

	// register codes
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_RATE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MINUTE_RATE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HOUR_RATE   = 3'd4;

	// quadrant codes
	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	localparam logic [31:0] CENTER_X_RST    = 32'd32768000;
	localparam logic [31:0] CENTER_Y_RST    = 32'd19660800;
	localparam logic [31:0] SECOND_RATE_RST = 32'd71583;
	localparam logic [31:0] MINUTE_RATE_RST = 32'd1193;
	localparam logic [31:0] HOUR_RATE_RST   = 32'd20;
	localparam logic [31:0] TIP_X_RST       = 32'd32768000;

	typedef struct packed {
		logic load;
		logic step;
	} cordic_ctl_t;

	typedef struct packed {
		logic lo;
		logic hi;
	} scale_ctl_t;

	// 100, 150, 200 ... pixels in Q16.16
	function automatic logic [31:0] tip_y_rst(input int k);
		return 32'((100 + 50 * k) * 65536);
	endfunction

	// arctangent of 2^-i, in 2^-32 turn
	function automatic logic [31:0] atan_turn(input logic [IDX_W-1:0] i);
		logic [31:0] a;
		case (i)
			5'd0:  a = 32'h2000_0000;
			5'd1:  a = 32'h12E4_051E;
			5'd2:  a = 32'h09FB_385B;
			5'd3:  a = 32'h0511_11D4;
			5'd4:  a = 32'h028B_0D43;
			5'd5:  a = 32'h0145_D7E1;
			5'd6:  a = 32'h00A2_F61E;
			5'd7:  a = 32'h0051_7C55;
			5'd8:  a = 32'h0028_BE53;
			5'd9:  a = 32'h0014_5F2F;
			5'd10: a = 32'h000A_2F98;
			5'd11: a = 32'h0005_17CC;
			5'd12: a = 32'h0002_8BE6;
			5'd13: a = 32'h0001_45F3;
			5'd14: a = 32'h0000_A2FA;
			5'd15: a = 32'h0000_517D;
			5'd16: a = 32'h0000_28BE;
			5'd17: a = 32'h0000_145F;
			5'd18: a = 32'h0000_0A30;
			5'd19: a = 32'h0000_0518;
			5'd20: a = 32'h0000_028C;
			5'd21: a = 32'h0000_0146;
			5'd22: a = 32'h0000_00A3;
			5'd23: a = 32'h0000_0051;
			5'd24: a = 32'h0000_0029;
			5'd25: a = 32'h0000_0014;
			5'd26: a = 32'h0000_000A;
			5'd27: a = 32'h0000_0005;
			5'd28: a = 32'h0000_0003;
			5'd29: a = 32'h0000_0001;
			5'd30: a = 32'h0000_0001;
			default: a = 32'h0000_0000;
		endcase
		return a;
	endfunction

endpackage

// ===== hw/rtl/rtpc_if.sv =====
// ----------------------------------------------------------------------------
// Clock hand rotator: channel interfaces
// Tick request channel and hand tip result channel, valid/ready.
// ----------------------------------------------------------------------------
interface rtpc_tick_if;
	import rtpc_pkg::*;

	logic            valid;
	logic            ready;
	logic [MS_W-1:0] elapsed_ms;

	modport source (output valid, output elapsed_ms, input ready);
	modport sink (input valid, input elapsed_ms, output ready);
endinterface

interface rtpc_tip_if;
	import rtpc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] second_x;
	logic signed [COORD_W-1:0] second_y;
	logic signed [COORD_W-1:0] minute_x;
	logic signed [COORD_W-1:0] minute_y;
	logic signed [COORD_W-1:0] hour_x;
	logic signed [COORD_W-1:0] hour_y;

	modport source (output valid, output second_x, output second_y, output minute_x,
		output minute_y, output hour_x, output hour_y, input ready);
	modport sink (input valid, input second_x, input second_y, input minute_x,
		input minute_y, input hour_x, input hour_y, output ready);
endinterface

// ===== hw/rtl/rtpc_cordic.sv =====
// ----------------------------------------------------------------------------
// Clock hand rotator: CORDIC micro-rotation unit
// Loads the tip offset with quadrant pre-rotation, then one step per cycle while ctl.step is set.
// ----------------------------------------------------------------------------
module rtpc_cordic (
	input  logic                                clk,
	input  rtpc_pkg::cordic_ctl_t               ctl,
	input  logic [rtpc_pkg::IDX_W-1:0]          idx,
	input  logic signed [rtpc_pkg::COORD_W-1:0] tip_x,
	input  logic signed [rtpc_pkg::COORD_W-1:0] tip_y,
	input  logic signed [rtpc_pkg::COORD_W-1:0] center_x,
	input  logic signed [rtpc_pkg::COORD_W-1:0] center_y,
	input  logic [31:0]                         angle,
	output logic signed [rtpc_pkg::XY_W-1:0]    x,
	output logic signed [rtpc_pkg::XY_W-1:0]    y
);
	import rtpc_pkg::*;

	logic signed [XY_W-1:0] x_q, y_q;
	logic signed [31:0]     z_q;

	logic signed [COORD_W:0] off_x, off_y;
	logic signed [XY_W-1:0]  x0, y0, x_pre, y_pre;
	logic [31:0]             ang_sum;
	logic [1:0]              quad;
	logic signed [31:0]      z0;
	logic signed [XY_W-1:0]  xs, ys;
	logic signed [31:0]      at;

	always_comb begin
		off_x = {tip_x[COORD_W-1], tip_x} - {center_x[COORD_W-1], center_x};
		off_y = {tip_y[COORD_W-1], tip_y} - {center_y[COORD_W-1], center_y};
		x0    = {{(XY_W-COORD_W-5){off_x[COORD_W]}}, off_x, 4'b0000};
		y0    = {{(XY_W-COORD_W-5){off_y[COORD_W]}}, off_y, 4'b0000};
		ang_sum = angle + HALF_QUAD;
		quad    = ang_sum[31:30];
		z0      = $signed(angle - {quad, 30'b0});
		case (quad)
			QUAD_0: begin
				x_pre = x0;
				y_pre = y0;
			end
			QUAD_1: begin
				x_pre = -y0;
				y_pre = x0;
			end
			QUAD_2: begin
				x_pre = -x0;
				y_pre = -y0;
			end
			QUAD_3: begin
				x_pre = y0;
				y_pre = -x0;
			end
			default: begin
				x_pre = x0;
				y_pre = y0;
			end
		endcase
		xs = x_q >>> idx;
		ys = y_q >>> idx;
		at = $signed(atan_turn(idx));
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= x_pre;
			y_q <= y_pre;
			z_q <= z0;
		end else if (ctl.step) begin
			if (!z_q[31]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign x = x_q;
	assign y = y_q;

endmodule

// ===== hw/rtl/rtpc_scale.sv =====
// ----------------------------------------------------------------------------
// Clock hand rotator: gain scaler
// Multiplies by the inverse CORDIC gain in two partial products, then rounds,
// adds the center and saturates to Q16.16.
// ----------------------------------------------------------------------------
module rtpc_scale (
	input  logic                                clk,
	input  rtpc_pkg::scale_ctl_t                ctl,
	input  logic signed [rtpc_pkg::XY_W-1:0]    operand,
	input  logic signed [rtpc_pkg::COORD_W-1:0] center,
	output logic signed [rtpc_pkg::COORD_W-1:0] result
);
	import rtpc_pkg::*;

	localparam int RND_W  = ACC_W - OUT_SHIFT;
	localparam int PROD_W = 46;

	logic signed [ACC_W-1:0] acc_q;

	logic signed [20:0]       mul_a;
	logic signed [PROD_W-1:0] prod;
	logic signed [RND_W-1:0]  rnd;
	logic signed [RND_W:0]    sum;

	// one multiplier: low 20 bits unsigned first, signed upper part second
	assign mul_a = ctl.hi ? $signed({operand[XY_W-1], operand[XY_W-1:20]})
	                      : $signed({1'b0, operand[19:0]});
	assign prod  = mul_a * $signed({1'b0, GAIN_Q24});

	always_ff @(posedge clk) begin
		if (ctl.lo) begin
			// rounding half folded in here
			acc_q <= $signed({{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod})
				+ $signed(ACC_W'(64'd1 << (OUT_SHIFT - 1)));
		end else if (ctl.hi) begin
			acc_q <= acc_q + $signed({prod[43:0], 20'b0});
		end
	end

	always_comb begin
		rnd = acc_q[ACC_W-1:OUT_SHIFT];
		sum = {{(RND_W + 1 - COORD_W){center[COORD_W-1]}}, center} + {rnd[RND_W-1], rnd};
		if (!sum[RND_W] && (sum[RND_W-1:COORD_W-1] != '0)) begin
			result = {1'b0, {(COORD_W-1){1'b1}}};
		end else if (sum[RND_W] && (sum[RND_W-1:COORD_W-1] != '1)) begin
			result = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			result = sum[COORD_W-1:0];
		end
	end

endmodule

// ===== hw/rtl/rotate_three_points_about_center.sv =====
// ----------------------------------------------------------------------------
// Clock hand rotator: top level
// Turns each hand tip about the center by rate * elapsed ms per tick request.
// ----------------------------------------------------------------------------
// Each tick request carries elapsed_ms; every hand is rotated in turn through
// one shared CORDIC micro-rotation stage (one step per cycle) and one shared
// 21x25 partial-product multiplier, and a single result with all six tip
// coordinates follows. A request is taken only in S_IDLE, so a new one is
// not accepted until the sequencer has finished the last one and registered
// its result; the next request may be accepted while a result still waits
// on tip_ch. Config writes must only be made while no request is in flight.
`include "rotate_three_points_about_center_defines.svh"

module rotate_three_points_about_center #(
	parameter int HAND_COUNT   = 3,
	parameter int CORDIC_STEPS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	rtpc_tick_if.sink                         tick_ch,
	rtpc_tip_if.source                        tip_ch,
	input  logic                              cfg_we,
	input  logic [rtpc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rtpc_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import rtpc_pkg::*;

	localparam int HAND_W = (HAND_COUNT > 1) ? $clog2(HAND_COUNT) : 1;
	localparam int STEP_W = $clog2(CORDIC_STEPS);
	localparam logic [HAND_W-1:0] HAND_LAST = HAND_W'(HAND_COUNT - 1);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_ANGLE = 11'b000_0000_0010,
		S_LOAD  = 11'b000_0000_0100,
		S_ITER  = 11'b000_0000_1000,
		S_X_LO  = 11'b000_0001_0000,
		S_X_HI  = 11'b000_0010_0000,
		S_X_WR  = 11'b000_0100_0000,
		S_Y_LO  = 11'b000_1000_0000,
		S_Y_HI  = 11'b001_0000_0000,
		S_Y_WR  = 11'b010_0000_0000,
		S_DONE  = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	logic signed [COORD_W-1:0] center_x_q, center_y_q;
	logic [31:0]               second_rate_q, minute_rate_q, hour_rate_q;
	logic signed [COORD_W-1:0] tip_x_q [HAND_COUNT];
	logic signed [COORD_W-1:0] tip_y_q [HAND_COUNT];

	logic [HAND_W-1:0] hand_q;
	logic [STEP_W-1:0] step_q;
	logic [MS_W-1:0]   ms_q;
	logic [31:0]       angle_q;
	logic              out_valid_q;
	logic signed [COORD_W-1:0] out_x_q [3];
	logic signed [COORD_W-1:0] out_y_q [3];

	logic                      in_acc, out_free, sel_y;
	logic [31:0]               rate_sel;
	logic [47:0]               ang_full;
	cordic_ctl_t               cordic_ctl;
	scale_ctl_t                scale_ctl;
	logic signed [XY_W-1:0]    cx, cy, scale_op;
	logic signed [COORD_W-1:0] scale_res, scale_center;
	logic signed [COORD_W-1:0] res_x [3];
	logic signed [COORD_W-1:0] res_y [3];

	assign tick_ch.ready = (state_q == S_IDLE);
	assign in_acc        = tick_ch.valid && tick_ch.ready;
	assign out_free      = !out_valid_q || tip_ch.ready;

	always_comb begin
		if (hand_q == '0) begin
			rate_sel = second_rate_q;
		end else if (hand_q == HAND_W'(1)) begin
			rate_sel = minute_rate_q;
		end else begin
			rate_sel = hour_rate_q;
		end
		ang_full = rate_sel * ms_q;

		cordic_ctl.load = (state_q == S_LOAD);
		cordic_ctl.step = (state_q == S_ITER);
		scale_ctl.lo    = (state_q == S_X_LO) || (state_q == S_Y_LO);
		scale_ctl.hi    = (state_q == S_X_HI) || (state_q == S_Y_HI);
		sel_y           = (state_q == S_Y_LO) || (state_q == S_Y_HI) || (state_q == S_Y_WR);
		scale_op        = sel_y ? cy : cx;
		scale_center    = sel_y ? center_y_q : center_x_q;
	end

	rtpc_cordic u_cordic (
		.clk      (clk),
		.ctl      (cordic_ctl),
		.idx      (IDX_W'(step_q)),
		.tip_x    (tip_x_q[hand_q]),
		.tip_y    (tip_y_q[hand_q]),
		.center_x (center_x_q),
		.center_y (center_y_q),
		.angle    (angle_q),
		.x        (cx),
		.y        (cy)
	);

	rtpc_scale u_scale (
		.clk     (clk),
		.ctl     (scale_ctl),
		.operand (scale_op),
		.center  (scale_center),
		.result  (scale_res)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q    <= CENTER_X_RST;
			center_y_q    <= CENTER_Y_RST;
			second_rate_q <= SECOND_RATE_RST;
			minute_rate_q <= MINUTE_RATE_RST;
			hour_rate_q   <= HOUR_RATE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CENTER_X:    center_x_q    <= cfg_data;
				CFG_CENTER_Y:    center_y_q    <= cfg_data;
				CFG_SECOND_RATE: second_rate_q <= cfg_data;
				CFG_MINUTE_RATE: minute_rate_q <= cfg_data;
				CFG_HOUR_RATE:   hour_rate_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// hand tips
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < HAND_COUNT; k++) begin
				tip_x_q[k] <= TIP_X_RST;
				tip_y_q[k] <= tip_y_rst(k);
			end
		end else if (state_q == S_X_WR) begin
			tip_x_q[hand_q] <= scale_res;
		end else if (state_q == S_Y_WR) begin
			tip_y_q[hand_q] <= scale_res;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hand_q  <= '0;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						hand_q  <= '0;
						state_q <= S_ANGLE;
					end
				end
				S_ANGLE: state_q <= S_LOAD;
				S_LOAD: begin
					step_q  <= '0;
					state_q <= S_ITER;
				end
				S_ITER: begin
					if (step_q == STEP_LAST) begin
						state_q <= S_X_LO;
					end else begin
						step_q <= step_q + STEP_W'(1);
					end
				end
				S_X_LO: state_q <= S_X_HI;
				S_X_HI: state_q <= S_X_WR;
				S_X_WR: state_q <= S_Y_LO;
				S_Y_LO: state_q <= S_Y_HI;
				S_Y_HI: state_q <= S_Y_WR;
				S_Y_WR: begin
					if (hand_q == HAND_LAST) begin
						state_q <= S_DONE;
					end else begin
						hand_q  <= hand_q + HAND_W'(1);
						state_q <= S_ANGLE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ms_q <= tick_ch.elapsed_ms;
		end
		if (state_q == S_ANGLE) begin
			angle_q <= ang_full[31:0];
		end
	end

	// missing hands read as zero
	for (genvar k = 0; k < 3; k++) begin : g_res
		if (k < HAND_COUNT) begin : g_hand
			assign res_x[k] = tip_x_q[k];
			assign res_y[k] = tip_y_q[k];
		end else begin : g_none
			assign res_x[k] = '0;
			assign res_y[k] = '0;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (tip_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			for (int k = 0; k < 3; k++) begin
				out_x_q[k] <= res_x[k];
				out_y_q[k] <= res_y[k];
			end
		end
	end

	assign tip_ch.valid    = out_valid_q;
	assign tip_ch.second_x = out_x_q[0];
	assign tip_ch.second_y = out_y_q[0];
	assign tip_ch.minute_x = out_x_q[1];
	assign tip_ch.minute_y = out_y_q[1];
	assign tip_ch.hour_x   = out_x_q[2];
	assign tip_ch.hour_y   = out_y_q[2];

	`RTPC_ASSERT_NEXT(a_accept_starts, in_acc, state_q == S_ANGLE, "request did not start a hand")
	`RTPC_ASSERT_NOW(a_step_bound, state_q == S_ITER, step_q <= STEP_LAST, "CORDIC step out of range")
	`RTPC_ASSERT_NEXT(a_iter_ends, (state_q == S_ITER) && (step_q == STEP_LAST),
		state_q == S_X_LO, "CORDIC did not hand over to scaler")
	`RTPC_ASSERT_NEXT(a_last_hand, (state_q == S_Y_WR) && (hand_q == HAND_LAST),
		state_q == S_DONE, "last hand did not finish request")
	`RTPC_ASSERT_NEXT(a_result_out, (state_q == S_DONE) && out_free,
		out_valid_q && (state_q == S_IDLE), "finished request not presented")

endmodule
